### rtl/sdf_pkg.sv
// Shared constants, types and saturation helpers for the spring damper force block.
`default_nettype none

package sdf_pkg;

  localparam int D_W         = 32;
  localparam int REST_W      = 31;
  localparam int GAIN_W      = 16;
  localparam int LEN_W       = 32;
  localparam int SQ_W        = 64;
  localparam int SQRT_STAGES = 32;
  localparam int DIR_BITS    = 30;
  localparam int QUO_W       = 31;
  localparam int DIV_STAGES  = QUO_W;
  localparam int REM_W       = LEN_W + 1;
  localparam int STR_W       = 34;
  localparam int DIR_W       = 32;
  localparam int PROD_W      = 64;
  localparam int AXS_W       = 66;
  localparam int AX_W        = AXS_W - DIR_BITS;
  localparam int SPR_W       = 50;
  localparam int DMP_W       = 51;
  localparam int MAG_W       = 50;
  localparam int UB_W        = 31;
  localparam int HI_W        = MAG_W - DIR_BITS;
  localparam int PH_W        = HI_W + UB_W;
  localparam int PL_W        = DIR_BITS + UB_W;
  localparam int R_W         = 52;
  localparam int SV_W        = R_W + 1;
  localparam int SUM_W       = SV_W + 1;
  localparam int OUT_W       = 48;
  localparam int ST_W        = 32;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [GAIN_W-1:0] STIFFNESS_RST = GAIN_W'(10000);
  localparam logic [GAIN_W-1:0] DAMPING_RST   = GAIN_W'(30);

  typedef enum logic [0:0] {
    REG_STIFFNESS = 1'b0,
    REG_DAMPING   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] stiffness;
    logic [GAIN_W-1:0] damping;
  } cfg_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] d_mag;
    logic [2:0]          d_neg;
    logic [2:0][D_W-1:0] vel;
    logic [REST_W-1:0]   rest;
    logic                warp;
  } sq_side_t;

  typedef struct packed {
    logic [2:0]          d_neg;
    logic [2:0][D_W-1:0] vel;
    logic [STR_W-1:0]    stretch;
    logic                warp;
    logic                len_zero;
  } div_side_t;

  typedef struct packed {
    logic [2:0][OUT_W-1:0] force_v;
    logic [2:0][OUT_W-1:0] compress;
    logic [ST_W-1:0]       stretch;
    logic                  warp;
  } result_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [SUM_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v[SUM_W-1:OUT_W-1] == {(SUM_W-OUT_W+1){v[SUM_W-1]}}) begin
      r = v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [ST_W-1:0] sat_stretch(input logic [STR_W-1:0] v);
    logic [ST_W-1:0] r;
    if (v[STR_W-1:ST_W-1] == {(STR_W-ST_W+1){v[STR_W-1]}}) begin
      r = v[ST_W-1:0];
    end else if (v[STR_W-1]) begin
      r = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sdf_if.sv
// Valid/ready channel interfaces for link items and force results.
`default_nettype none

interface sdf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rel_pos_x;
  logic signed [31:0] rel_pos_y;
  logic signed [31:0] rel_pos_z;
  logic signed [31:0] rel_vel_x;
  logic signed [31:0] rel_vel_y;
  logic signed [31:0] rel_vel_z;
  logic [30:0]        rest_length;
  logic               is_warp;

  modport source (output valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y,
                  rel_vel_z, rest_length, is_warp, input ready);
  modport sink (input valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y,
                rel_vel_z, rest_length, is_warp, output ready);
endinterface

interface sdf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic signed [47:0] compress_x;
  logic signed [47:0] compress_y;
  logic signed [47:0] compress_z;
  logic signed [31:0] stretch_amount;
  logic               axis_warp;

  modport source (output valid, force_x, force_y, force_z, compress_x, compress_y,
                  compress_z, stretch_amount, axis_warp, input ready);
  modport sink (input valid, force_x, force_y, force_z, compress_x, compress_y,
                compress_z, stretch_amount, axis_warp, output ready);
endinterface

`default_nettype wire

### rtl/sdf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module sdf_sqrt import sdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SQ_W-1:0]  in_sumsq,
  input  sq_side_t         in_side,
  output logic             out_valid,
  output logic [LEN_W-1:0] out_len,
  output sq_side_t         out_side
);

  logic [SQ_W-1:0] n_cur   [SQRT_STAGES];
  logic [SQ_W-1:0] res_cur [SQRT_STAGES];
  logic            vld_cur [SQRT_STAGES];
  sq_side_t        side_cur[SQRT_STAGES];
  logic [SQ_W-1:0] n_r     [SQRT_STAGES];
  logic [SQ_W-1:0] res_r   [SQRT_STAGES];
  logic            valid_r [SQRT_STAGES];
  sq_side_t        side_r  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_nxt;
    logic [SQ_W-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign n_cur[k]    = in_sumsq;
      assign res_cur[k]  = '0;
      assign vld_cur[k]  = in_valid;
      assign side_cur[k] = in_side;
    end else begin : g_next
      assign n_cur[k]    = n_r[k-1];
      assign res_cur[k]  = res_r[k-1];
      assign vld_cur[k]  = valid_r[k-1];
      assign side_cur[k] = side_r[k-1];
    end

    always_comb begin
      trial = res_cur[k] + BIT_K;
      if (n_cur[k] >= trial) begin
        n_nxt   = n_cur[k] - trial;
        res_nxt = (res_cur[k] >> 1) + BIT_K;
      end else begin
        n_nxt   = n_cur[k];
        res_nxt = res_cur[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= vld_cur[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= side_cur[k];
      end
    end
  end

  assign out_valid = valid_r[SQRT_STAGES-1];
  assign out_len   = res_r[SQRT_STAGES-1][LEN_W-1:0];
  assign out_side  = side_r[SQRT_STAGES-1];

endmodule

`default_nettype wire

### rtl/sdf_div.sv
// Three-lane pipelined restoring divider forming the unsigned Q1.30 link direction magnitudes.
`default_nettype none

module sdf_div import sdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [LEN_W-1:0]      in_len,
  input  logic [2:0][D_W-1:0]   in_mag,
  input  div_side_t             in_side,
  output logic                  out_valid,
  output logic [2:0][QUO_W-1:0] out_quo,
  output div_side_t             out_side
);

  logic [2:0][LEN_W-1:0] rem_cur [DIV_STAGES];
  logic [2:0][QUO_W-1:0] quo_cur [DIV_STAGES];
  logic [2:0]            lsb_cur [DIV_STAGES];
  logic [LEN_W-1:0]      len_cur [DIV_STAGES];
  logic                  vld_cur [DIV_STAGES];
  div_side_t             side_cur[DIV_STAGES];
  logic [2:0][LEN_W-1:0] rem_r   [DIV_STAGES];
  logic [2:0][QUO_W-1:0] quo_r   [DIV_STAGES];
  logic [LEN_W-1:0]      len_r   [DIV_STAGES];
  logic                  valid_r [DIV_STAGES];
  div_side_t             side_r  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [2:0][REM_W-1:0] sh;
    logic [2:0][LEN_W-1:0] rem_nxt;
    logic [2:0][QUO_W-1:0] quo_nxt;

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_cur[j][i] = in_mag[i] >> 1;
        assign lsb_cur[j][i] = in_mag[i][0];
      end
      assign quo_cur[j]  = '0;
      assign len_cur[j]  = in_len;
      assign vld_cur[j]  = in_valid;
      assign side_cur[j] = in_side;
    end else begin : g_next
      assign rem_cur[j]  = rem_r[j-1];
      assign lsb_cur[j]  = '0;
      assign quo_cur[j]  = quo_r[j-1];
      assign len_cur[j]  = len_r[j-1];
      assign vld_cur[j]  = valid_r[j-1];
      assign side_cur[j] = side_r[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {rem_cur[j][i], lsb_cur[j][i]};
        if (sh[i] >= {1'b0, len_cur[j]}) begin
          rem_nxt[i] = LEN_W'(sh[i] - {1'b0, len_cur[j]});
          quo_nxt[i] = {quo_cur[j][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = sh[i][LEN_W-1:0];
          quo_nxt[i] = {quo_cur[j][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (en) begin
        valid_r[j] <= vld_cur[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        quo_r[j]  <= quo_nxt;
        len_r[j]  <= len_cur[j];
        side_r[j] <= side_cur[j];
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/sdf_back.sv
// Force back end: direction, damping projection, split products and saturation.
`default_nettype none

module sdf_back import sdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  input  logic [2:0][QUO_W-1:0] in_quo,
  input  div_side_t             in_side,
  output logic                  out_valid,
  output result_t               out_res
);

  // direction
  logic [2:0][DIR_W-1:0] qx;
  logic [2:0][DIR_W-1:0] dir5_nxt;
  logic                  v5_r;
  logic [2:0][DIR_W-1:0] dir5_r;
  logic [2:0][D_W-1:0]   vel5_r;
  logic [STR_W-1:0]      str5_r;
  logic                  warp5_r;

  // velocity products and spring
  logic [2:0][PROD_W-1:0] prod6_nxt;
  logic [SPR_W-1:0]       spr6_nxt;
  logic                   v6_r;
  logic [2:0][PROD_W-1:0] prod6_r;
  logic [SPR_W-1:0]       spr6_r;
  logic [2:0][DIR_W-1:0]  dir6_r;
  logic [STR_W-1:0]       str6_r;
  logic                   warp6_r;

  // axial sum
  logic [AXS_W-1:0]      axs7_nxt;
  logic                  v7_r;
  logic [AXS_W-1:0]      axs7_r;
  logic [SPR_W-1:0]      spr7_r;
  logic [2:0][DIR_W-1:0] dir7_r;
  logic [STR_W-1:0]      str7_r;
  logic                  warp7_r;

  // axial truncation
  logic [AXS_W-1:0]      axt8;
  logic                  v8_r;
  logic [AX_W-1:0]       ax8_r;
  logic [SPR_W-1:0]      spr8_r;
  logic [2:0][DIR_W-1:0] dir8_r;
  logic [STR_W-1:0]      str8_r;
  logic                  warp8_r;

  // damping
  logic [DMP_W-1:0]      dmp9_nxt;
  logic                  v9_r;
  logic [DMP_W-1:0]      dmp9_r;
  logic [SPR_W-1:0]      spr9_r;
  logic [2:0][DIR_W-1:0] dir9_r;
  logic [STR_W-1:0]      str9_r;
  logic                  warp9_r;

  // magnitudes
  logic [2:0][DIR_W-1:0] dm10;
  logic                  v10_r;
  logic [MAG_W-1:0]      usp10_r;
  logic [MAG_W-1:0]      udp10_r;
  logic [2:0][UB_W-1:0]  ub10_r;
  logic [2:0]            nsp10_r;
  logic [2:0]            ndp10_r;
  logic [STR_W-1:0]      str10_r;
  logic                  warp10_r;

  // partial products
  logic                 v11_r;
  logic [2:0][PH_W-1:0] sph11_r;
  logic [2:0][PL_W-1:0] spl11_r;
  logic [2:0][PH_W-1:0] dph11_r;
  logic [2:0][PL_W-1:0] dpl11_r;
  logic [2:0]           nsp11_r;
  logic [2:0]           ndp11_r;
  logic [STR_W-1:0]     str11_r;
  logic                 warp11_r;

  // combined magnitudes
  logic                 v12_r;
  logic [2:0][R_W-1:0]  rsp12_r;
  logic [2:0][R_W-1:0]  rdp12_r;
  logic [2:0]           nsp12_r;
  logic [2:0]           ndp12_r;
  logic [STR_W-1:0]     str12_r;
  logic                 warp12_r;

  // signed values
  logic                 v13_r;
  logic [2:0][SV_W-1:0] sp13_r;
  logic [2:0][SV_W-1:0] dp13_r;
  logic [2:0][SV_W-1:0] cp13_r;
  logic [ST_W-1:0]      st13_r;
  logic                 warp13_r;

  result_t res_nxt;
  logic    v14_r;
  result_t res14_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = DIR_W'(in_quo[i]);
      if (in_side.len_zero) begin
        dir5_nxt[i] = '0;
      end else if (in_side.d_neg[i]) begin
        dir5_nxt[i] = -qx[i];
      end else begin
        dir5_nxt[i] = qx[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod6_nxt[i] = $signed(vel5_r[i]) * $signed(dir5_r[i]);
    end
    spr6_nxt = $signed({1'b0, cfg.stiffness}) * $signed(str5_r);
  end

  assign axs7_nxt = $signed(prod6_r[0]) + $signed(prod6_r[1]) + $signed(prod6_r[2]);

  assign axt8 = axs7_r + {{(AXS_W-DIR_BITS){1'b0}}, {DIR_BITS{axs7_r[AXS_W-1]}}};

  assign dmp9_nxt = $signed({1'b0, cfg.damping}) * $signed(ax8_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm10[i] = dir9_r[i][DIR_W-1] ? -dir9_r[i] : dir9_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_nxt.force_v[i]  = sat_out(SUM_W'($signed(sp13_r[i])) + SUM_W'($signed(dp13_r[i])));
      res_nxt.compress[i] = sat_out(SUM_W'($signed(cp13_r[i])));
    end
    res_nxt.stretch = st13_r;
    res_nxt.warp    = warp13_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
    end else if (en) begin
      v5_r  <= in_valid;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir5_r  <= dir5_nxt;
      vel5_r  <= in_side.vel;
      str5_r  <= in_side.stretch;
      warp5_r <= in_side.warp;

      prod6_r <= prod6_nxt;
      spr6_r  <= spr6_nxt;
      dir6_r  <= dir5_r;
      str6_r  <= str5_r;
      warp6_r <= warp5_r;

      axs7_r  <= axs7_nxt;
      spr7_r  <= spr6_r;
      dir7_r  <= dir6_r;
      str7_r  <= str6_r;
      warp7_r <= warp6_r;

      ax8_r   <= axt8[AXS_W-1:DIR_BITS];
      spr8_r  <= spr7_r;
      dir8_r  <= dir7_r;
      str8_r  <= str7_r;
      warp8_r <= warp7_r;

      dmp9_r  <= dmp9_nxt;
      spr9_r  <= spr8_r;
      dir9_r  <= dir8_r;
      str9_r  <= str8_r;
      warp9_r <= warp8_r;

      usp10_r  <= spr9_r[SPR_W-1] ? -spr9_r : spr9_r;
      udp10_r  <= MAG_W'(dmp9_r[DMP_W-1] ? -dmp9_r : dmp9_r);
      for (int i = 0; i < 3; i++) begin
        ub10_r[i]  <= dm10[i][UB_W-1:0];
        nsp10_r[i] <= spr9_r[SPR_W-1] ^ dir9_r[i][DIR_W-1];
        ndp10_r[i] <= dmp9_r[DMP_W-1] ^ dir9_r[i][DIR_W-1];
      end
      str10_r  <= str9_r;
      warp10_r <= warp9_r;

      for (int i = 0; i < 3; i++) begin
        sph11_r[i] <= usp10_r[MAG_W-1:DIR_BITS] * ub10_r[i];
        spl11_r[i] <= usp10_r[DIR_BITS-1:0] * ub10_r[i];
        dph11_r[i] <= udp10_r[MAG_W-1:DIR_BITS] * ub10_r[i];
        dpl11_r[i] <= udp10_r[DIR_BITS-1:0] * ub10_r[i];
      end
      nsp11_r  <= nsp10_r;
      ndp11_r  <= ndp10_r;
      str11_r  <= str10_r;
      warp11_r <= warp10_r;

      for (int i = 0; i < 3; i++) begin
        rsp12_r[i] <= R_W'(sph11_r[i]) + R_W'(spl11_r[i][PL_W-1:DIR_BITS]);
        rdp12_r[i] <= R_W'(dph11_r[i]) + R_W'(dpl11_r[i][PL_W-1:DIR_BITS]);
      end
      nsp12_r  <= nsp11_r;
      ndp12_r  <= ndp11_r;
      str12_r  <= str11_r;
      warp12_r <= warp11_r;

      for (int i = 0; i < 3; i++) begin
        sp13_r[i] <= nsp12_r[i] ? -SV_W'(rsp12_r[i]) : SV_W'(rsp12_r[i]);
        dp13_r[i] <= ndp12_r[i] ? -SV_W'(rdp12_r[i]) : SV_W'(rdp12_r[i]);
        cp13_r[i] <= (nsp12_r[i] ^ ~warp12_r) ? -SV_W'(rsp12_r[i]) : SV_W'(rsp12_r[i]);
      end
      st13_r   <= sat_stretch(str12_r);
      warp13_r <= warp12_r;

      res14_r <= res_nxt;
    end
  end

  assign out_valid = v14_r;
  assign out_res   = res14_r;

endmodule

`default_nettype wire

### rtl/spring_damper_force.sv
// Top level of the damped spring link force pipeline with its register port.
//
// One link per clock cycle enters and, when the result side keeps taking,
// one result leaves per cycle. From acceptance to its result each link
// passes three front stages forming the squared length, a 32-stage square
// root giving the length, a 31-stage three-lane divider giving the unit
// direction and ten back stages forming the spring, damping and saturated
// outputs. The whole pipeline holds while a finished result is not taken.
// Stiffness sits at byte address 0 and damping at 4; the user must write
// both only while no link is in flight, which the block does not enforce.
`default_nettype none

module spring_damper_force import sdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sdf_in_if.sink            in_chan,
  sdf_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic              en;
  logic              cfg_wr;
  reg_idx_t          cfg_sel;
  logic [GAIN_W-1:0] stiffness_r;
  logic [GAIN_W-1:0] damping_r;
  cfg_t              cfg;

  logic [2:0][D_W-1:0] pos_in;
  logic [2:0][D_W-1:0] vel_in;
  sq_side_t            side1_nxt;
  logic                v1_r;
  sq_side_t            side1_r;
  logic                v2_r;
  logic [2:0][SQ_W-1:0] sq2_r;
  sq_side_t            side2_r;
  logic                v3_r;
  logic [SQ_W-1:0]     sum3_r;
  sq_side_t            side3_r;

  logic             sqrt_valid;
  logic [LEN_W-1:0] sqrt_len;
  sq_side_t         sqrt_side;
  div_side_t        div_side_in;

  logic                  div_valid;
  logic [2:0][QUO_W-1:0] div_quo;
  div_side_t             div_side_out;

  logic    back_valid;
  result_t back_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_t'(paddr[CFG_AW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= STIFFNESS_RST;
      damping_r   <= DAMPING_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_STIFFNESS: stiffness_r <= pwdata[GAIN_W-1:0];
        REG_DAMPING:   damping_r   <= pwdata[GAIN_W-1:0];
        default:       stiffness_r <= stiffness_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_STIFFNESS: prdata = CFG_DW'(stiffness_r);
      REG_DAMPING:   prdata = CFG_DW'(damping_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.stiffness = stiffness_r;
  assign cfg.damping   = damping_r;

  // advance every stage unless a finished result is waiting
  assign en            = !back_valid || out_chan.ready;
  assign in_chan.ready = en;

  assign pos_in = {in_chan.rel_pos_z, in_chan.rel_pos_y, in_chan.rel_pos_x};
  assign vel_in = {in_chan.rel_vel_z, in_chan.rel_vel_y, in_chan.rel_vel_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side1_nxt.d_neg[i] = pos_in[i][D_W-1];
      side1_nxt.d_mag[i] = pos_in[i][D_W-1] ? -pos_in[i] : pos_in[i];
    end
    side1_nxt.vel  = vel_in;
    side1_nxt.rest = in_chan.rest_length;
    side1_nxt.warp = in_chan.is_warp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= side1_r.d_mag[i] * side1_r.d_mag[i];
      end
      side2_r <= side1_r;
      sum3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      side3_r <= side2_r;
    end
  end

  sdf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_sumsq  (sum3_r),
    .in_side   (side3_r),
    .out_valid (sqrt_valid),
    .out_len   (sqrt_len),
    .out_side  (sqrt_side)
  );

  always_comb begin
    div_side_in.d_neg    = sqrt_side.d_neg;
    div_side_in.vel      = sqrt_side.vel;
    div_side_in.stretch  = $signed({2'b00, sqrt_len}) - $signed({3'b000, sqrt_side.rest});
    div_side_in.warp     = sqrt_side.warp;
    div_side_in.len_zero = (sqrt_len == '0);
  end

  sdf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sqrt_valid),
    .in_len    (sqrt_len),
    .in_mag    (sqrt_side.d_mag),
    .in_side   (div_side_in),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side_out)
  );

  sdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_quo    (div_quo),
    .in_side   (div_side_out),
    .out_valid (back_valid),
    .out_res   (back_res)
  );

  assign out_chan.valid          = back_valid;
  assign out_chan.force_x        = back_res.force_v[0];
  assign out_chan.force_y        = back_res.force_v[1];
  assign out_chan.force_z        = back_res.force_v[2];
  assign out_chan.compress_x     = back_res.compress[0];
  assign out_chan.compress_y     = back_res.compress[1];
  assign out_chan.compress_z     = back_res.compress[2];
  assign out_chan.stretch_amount = back_res.stretch;
  assign out_chan.axis_warp      = back_res.warp;

endmodule

`default_nettype wire
